// File: design/rvcp_pkg.sv
package rvcp_pkg;

  localparam int unsigned FrameLength = 19;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned SumFirst    = 2;
  localparam int unsigned SumLast     = 17;
  localparam int unsigned CheckPos    = 18;
  localparam logic [7:0]  SyncByte    = 8'hAA;

  localparam logic [CountWidth-1:0] CountFull = CountWidth'(FrameLength);
  localparam logic [CountWidth-1:0] CountOver = CountWidth'(FrameLength + 1);

  localparam int unsigned OutWidth = 104;

  typedef struct packed {
    logic [15:0] accel_z;
    logic [15:0] accel_y;
    logic [15:0] accel_x;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [7:0]  frame_index;
  } result_t;

endpackage

// File: design/rvcp_collect.sv
module rvcp_collect (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                line_idle_i,
  output logic                res_valid_o,
  output rvcp_pkg::result_t   res_o
);

  logic [rvcp_pkg::CountWidth-1:0] count_q, count_d;
  logic [7:0]                      sum_q, sum_d;
  logic [7:0]                      bytes_q [rvcp_pkg::FrameLength];
  logic                            store;
  logic                            in_sum;
  logic                            frame_ok;

  assign store  = take_i && !line_idle_i && (count_q < rvcp_pkg::CountFull);
  assign in_sum = (count_q >= rvcp_pkg::CountWidth'(rvcp_pkg::SumFirst)) &&
                  (count_q <= rvcp_pkg::CountWidth'(rvcp_pkg::SumLast));

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (take_i) begin
      if (line_idle_i) begin
        count_d = '0;
        sum_d   = '0;
      end else if (count_q < rvcp_pkg::CountFull) begin
        count_d = count_q + 1'b1;
        if (in_sum) begin
          sum_d = sum_q + rx_byte_i;
        end
      end else begin
        count_d = rvcp_pkg::CountOver;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      bytes_q[count_q] <= rx_byte_i;
    end
  end

  // Check the burst against length, header and checksum on the idle event
  assign frame_ok = (count_q == rvcp_pkg::CountFull) &&
                    (bytes_q[0] == rvcp_pkg::SyncByte) &&
                    (bytes_q[1] == rvcp_pkg::SyncByte) &&
                    (sum_q == bytes_q[rvcp_pkg::CheckPos]);

  assign res_valid_o = take_i && line_idle_i && frame_ok;

  always_comb begin
    res_o.frame_index = bytes_q[2];
    res_o.yaw         = {bytes_q[4],  bytes_q[3]};
    res_o.pitch       = {bytes_q[6],  bytes_q[5]};
    res_o.roll        = {bytes_q[8],  bytes_q[7]};
    res_o.accel_x     = {bytes_q[10], bytes_q[9]};
    res_o.accel_y     = {bytes_q[12], bytes_q[11]};
    res_o.accel_z     = {bytes_q[14], bytes_q[13]};
  end

endmodule

// File: design/rvcp_out_buf.sv
module rvcp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  rvcp_pkg::result_t in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output rvcp_pkg::result_t out_data_o,
  input  logic              out_ready_i
);

  logic              valid_q;
  logic              skid_valid_q;
  rvcp_pkg::result_t data_q;
  rvcp_pkg::result_t skid_q;
  logic              load;

  assign in_ready_o  = !skid_valid_q;
  assign load        = in_valid_i && !skid_valid_q;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        valid_q      <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        valid_q <= load;
      end
    end else if (load) begin
      // Output stalled: park the new transaction in the skid stage
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        data_q <= skid_q;
      end else if (load) begin
        data_q <= in_data_i;
      end
    end else if (load) begin
      skid_q <= in_data_i;
    end
  end

endmodule

// File: design/imu_rvc_frame_parser_unit.sv
// Parser for the serial frames of an IMU in RVC mode. Each slave transaction
// carries a received byte, or a line-idle event flagged in tuser. Bytes of a
// burst are collected in place; the idle event checks the burst (19 bytes,
// two 0xAA header bytes, 8-bit sum of bytes 2..17 equal to byte 18) and a
// good frame yields one master transaction with the index, yaw, pitch, roll
// and the three raw accelerations, all as little-endian int16 values. Bad
// frames are dropped silently, and every idle event starts a new burst.
// One transaction is taken per cycle while the slave side is not stalled; a
// result is registered from its idle event into an output register backed by a
// one-entry skid stage, so the slave side stalls only when both are full.
module imu_rvc_frame_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // rx_byte
  input  logic                          s_axis_tuser,  // line_idle
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // frame_index[7:0], yaw[23:8], pitch[39:24], roll[55:40],
  // accel_x[71:56], accel_y[87:72], accel_z[103:88]
  output logic [rvcp_pkg::OutWidth-1:0] m_axis_tdata
);

  logic              take;
  logic              res_valid;
  logic              buf_ready;
  rvcp_pkg::result_t res;
  rvcp_pkg::result_t out_res;

  assign take          = s_axis_tvalid && buf_ready;
  assign s_axis_tready = buf_ready;

  rvcp_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .rx_byte_i   (s_axis_tdata),
    .line_idle_i (s_axis_tuser),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rvcp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (buf_ready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_res;

endmodule
